// ===== sv/pfd_pkg.sv =====
package pfd_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned OFS_W      = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 9;

  localparam int unsigned MAX_SCREEN_WIDTH  = 256;
  localparam int unsigned MAX_SCREEN_HEIGHT = 256;
  localparam int unsigned STORE_DEPTH       = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
  localparam int unsigned ADDR_W            = $clog2(STORE_DEPTH);

  localparam int unsigned DIVD_W    = 17;
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_START = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH    = 4'd0,
    REG_WIN_LEFT        = 4'd1,
    REG_WIN_TOP         = 4'd2,
    REG_WIN_WIDTH       = 4'd3,
    REG_WIN_HEIGHT      = 4'd4,
    REG_SCALED_WIDTH    = 4'd5,
    REG_SCALED_HEIGHT   = 4'd6,
    REG_TRANSPARENT_KEY = 4'd7
  } reg_e;

endpackage

// ===== sv/pfd_if.sv =====
interface pfd_in_if;
  import pfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [PIX_W-1:0] pixel_value;
  logic [PIX_W-1:0] fill_value;
  modport source (output valid, command, pixel_value, fill_value, input ready);
  modport sink   (input valid, command, pixel_value, fill_value, output ready);
endinterface

interface pfd_out_if;
  import pfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic [POS_W-1:0] out_position;
  modport source (output valid, out_pixel, out_position, input ready);
  modport sink   (input valid, out_pixel, out_position, output ready);
endinterface

interface pfd_cfg_if;
  import pfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/palette_frame_downscaler.sv =====
// Nearest-neighbour downscaler for palette-index frames.
// in_i carries one item per handshake: a pixel, a start-of-frame or a clear
// command. Pixels arrive in raster order of the frame window and are written
// into a 64K-entry screen store at the window offset; with a transparent key
// set, a matching pixel takes the stored colour instead. out_o carries the
// composited pixel and its position in the scaled frame, at most one per pixel.
// cfg_i writes the eight size/offset/key registers and is always ready.
// A pixel item does its store access in IDLE, then computes the output position
// and loads the output register in RMW (a pixel beyond the window skips RMW).
// Clear sweeps the store one entry per cycle, with the input held off. The
// scaling steps come from a bank of four radix-2 dividers; the input is held
// off while they run, after reset and after each register write.
// The output register parts the two channels: while it holds an untaken item
// the block still accepts the next one and stalls only when a second result
// is ready; the pending pixel then waits in RMW.
// Reset clears the counters and the frame position and sets the registers to
// their defaults; the store holds no defined data until a clear or pixel
// writes it.
module palette_frame_downscaler (
  input  logic     clk_i,
  input  logic     rst_ni,
  pfd_in_if.sink   in_i,
  pfd_cfg_if.sink  cfg_i,
  pfd_out_if.source out_o
);
  import pfd_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_CALC  = 5'b00010,
    ST_IDLE  = 5'b00100,
    ST_RMW   = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_e;

  typedef struct packed {
    logic [SIZE_W-1:0] rem;
    logic [DIVD_W-1:0] dvd;
  } div_t;

  localparam int unsigned NDIV = 4;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(256)) r = SIZE_W'(256);
    return r;
  endfunction

  function automatic div_t div_step(div_t s, logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] sh;
    div_t            r;
    sh    = {s.rem, s.dvd[DIVD_W-1]};
    r.dvd = {s.dvd[DIVD_W-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      sh       = sh - {1'b0, d};
      r.dvd[0] = 1'b1;
    end
    r.rem = sh[SIZE_W-1:0];
    return r;
  endfunction

  // configuration
  logic [SIZE_W-1:0] scr_w_q, win_w_q, win_h_q, scl_w_q, scl_h_q, key_q;
  logic [OFS_W-1:0]  win_left_q, win_top_q;
  logic [SIZE_W-1:0] sw, ww, wh, ow, oh;
  logic              cfg_we;

  // control
  state_e            state_q, state_d;
  logic              calc_req_q, calc_req_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [SIZE_W-1:0] row_q, row_d;
  logic [OFS_W-1:0]  col_q, col_d;
  logic              ev_q, ev_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  div_t              div_q [NDIV];
  div_t              div_d [NDIV];
  div_t              div_n [NDIV];
  logic [SIZE_W-1:0] div_den [NDIV];
  logic [SIZE_W-1:0] qc_q, rc_q, qr_q, rr_q, qc_d, rc_d, qr_d, rr_d;
  logic [OFS_W-1:0]  ocol_q, ocol_d;
  logic [SIZE_W-1:0] accc_q, accc_d, orow_q, orow_d, accr_q, accr_d;
  logic [PIX_W-1:0]  pix_q, pix_d, fill_q, fill_d;
  logic              transp_q, transp_d;
  logic [PIX_W-1:0]  po_row_q, po_row_d, po_col_q, po_col_d;
  logic [POS_W-1:0]  last_q, last_d;
  logic [PIX_W-1:0]  out_pixel_q, out_pixel_d;
  logic [POS_W-1:0]  out_position_q, out_position_d;

  // store
  logic [PIX_W-1:0]  mem [STORE_DEPTH];
  logic [PIX_W-1:0]  rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0]  mem_wdata;

  // per-item logic
  logic              in_ready, accept, pix_go, drop, transp, col_wrap, line_end;
  logic [OFS_W-1:0]  col_e, ocol_e;
  logic [SIZE_W-1:0] accc_e;
  logic [SIZE_W:0]   addr_row, col_sum, col_n;
  logic [18:0]       addr_prod;
  logic [19:0]       addr_full;
  logic [ADDR_W-1:0] pix_addr;
  logic [SIZE_W:0]   ocol_s, accc_s, orow_s, accr_s;
  logic [DIVD_W-1:0] pos_full;
  logic [POS_W-1:0]  pos;
  logic              emit, out_free, out_load;

  assign sw = clamp_size(scr_w_q);
  assign ww = clamp_size(win_w_q);
  assign wh = clamp_size(win_h_q);
  assign ow = clamp_size(scl_w_q);
  assign oh = clamp_size(scl_h_q);

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  assign in_ready   = (state_q == ST_IDLE) && !calc_req_q;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  assign drop     = row_q >= wh;
  assign col_wrap = {1'b0, col_q} >= ww;
  assign col_e    = col_wrap ? '0 : col_q;
  assign ocol_e   = col_wrap ? '0 : ocol_q;
  assign accc_e   = col_wrap ? '0 : accc_q;
  assign transp   = !key_q[SIZE_W-1] && (key_q[PIX_W-1:0] == in_i.pixel_value);
  assign pix_go   = accept && (in_i.command == CMD_PIXEL) && !drop;

  assign addr_row  = {1'b0, row_q} + (SIZE_W+1)'(win_top_q);
  assign addr_prod = 19'(addr_row) * 19'(sw);
  assign col_sum   = (SIZE_W+1)'(col_e) + (SIZE_W+1)'(win_left_q);
  assign addr_full = 20'(addr_prod) + 20'(col_sum);
  assign pix_addr  = addr_full[ADDR_W-1:0];

  assign col_n    = (SIZE_W+1)'(col_e) + (SIZE_W+1)'(1);
  assign line_end = col_n >= {1'b0, ww};

  always_comb begin
    ocol_s = (SIZE_W+1)'(ocol_e) + (SIZE_W+1)'(qc_q);
    accc_s = (SIZE_W+1)'(accc_e) + (SIZE_W+1)'(rc_q);
    if (accc_s >= {1'b0, ww}) begin
      accc_s = accc_s - {1'b0, ww};
      ocol_s = ocol_s + (SIZE_W+1)'(1);
    end
    orow_s = (SIZE_W+1)'(orow_q) + (SIZE_W+1)'(qr_q);
    accr_s = (SIZE_W+1)'(accr_q) + (SIZE_W+1)'(rr_q);
    if (accr_s >= {1'b0, wh}) begin
      accr_s = accr_s - {1'b0, wh};
      orow_s = orow_s + (SIZE_W+1)'(1);
    end
  end

  assign pos_full = DIVD_W'(po_row_q) * DIVD_W'(ow) + DIVD_W'(po_col_q);
  assign pos      = pos_full[POS_W-1:0];
  assign emit     = !ev_q || (pos > last_q);
  assign out_free = !out_valid_q || out_o.ready;

  assign div_den[0] = ww;
  assign div_den[1] = wh;
  assign div_den[2] = ww;
  assign div_den[3] = wh;

  always_comb begin
    for (int i = 0; i < NDIV; i++) begin
      div_n[i] = div_step(div_q[i], div_den[i]);
    end
  end

  assign mem_we    = (state_q == ST_CLEAR) || (pix_go && !transp);
  assign mem_re    = pix_go && transp;
  assign mem_addr  = (state_q == ST_CLEAR) ? clr_addr_q : pix_addr;
  assign mem_wdata = (state_q == ST_CLEAR) ? fill_q : in_i.pixel_value;

  always_comb begin
    state_d        = state_q;
    calc_req_d     = calc_req_q;
    cnt_d          = cnt_q;
    clr_addr_d     = clr_addr_q;
    row_d          = row_q;
    col_d          = col_q;
    ev_d           = ev_q;
    div_d          = div_q;
    qc_d           = qc_q;
    rc_d           = rc_q;
    qr_d           = qr_q;
    rr_d           = rr_q;
    ocol_d         = ocol_q;
    accc_d         = accc_q;
    orow_d         = orow_q;
    accr_d         = accr_q;
    pix_d          = pix_q;
    fill_d         = fill_q;
    transp_d       = transp_q;
    po_row_d       = po_row_q;
    po_col_d       = po_col_q;
    last_d         = last_q;
    out_pixel_d    = out_pixel_q;
    out_position_d = out_position_q;
    out_load       = 1'b0;

    case (state_q)
      ST_LOAD: begin
        calc_req_d = 1'b0;
        cnt_d      = '0;
        div_d[0]   = '{rem: '0, dvd: DIVD_W'(ow)};
        div_d[1]   = '{rem: '0, dvd: DIVD_W'(oh)};
        div_d[2]   = '{rem: '0, dvd: DIVD_W'(DIVD_W'(col_q) * DIVD_W'(ow))};
        div_d[3]   = '{rem: '0, dvd: DIVD_W'(DIVD_W'(row_q) * DIVD_W'(oh))};
        state_d    = ST_CALC;
      end
      ST_CALC: begin
        div_d = div_n;
        cnt_d = cnt_q + CNT_W'(1);
        if (calc_req_q) begin
          state_d = ST_LOAD;
        end else if (cnt_q == CNT_LAST) begin
          qc_d    = div_n[0].dvd[SIZE_W-1:0];
          rc_d    = div_n[0].rem;
          qr_d    = div_n[1].dvd[SIZE_W-1:0];
          rr_d    = div_n[1].rem;
          ocol_d  = div_n[2].dvd[OFS_W-1:0];
          accc_d  = div_n[2].rem;
          orow_d  = div_n[3].dvd[SIZE_W-1:0];
          accr_d  = div_n[3].rem;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (calc_req_q) begin
          state_d = ST_LOAD;
        end else if (accept) begin
          case (in_i.command)
            CMD_PIXEL: begin
              if (!drop) begin
                pix_d    = in_i.pixel_value;
                transp_d = transp;
                po_row_d = orow_q[PIX_W-1:0];
                po_col_d = ocol_e;
                if (line_end) begin
                  col_d  = '0;
                  ocol_d = '0;
                  accc_d = '0;
                  row_d  = row_q + SIZE_W'(1);
                  orow_d = orow_s[SIZE_W-1:0];
                  accr_d = accr_s[SIZE_W-1:0];
                end else begin
                  col_d  = col_n[OFS_W-1:0];
                  ocol_d = ocol_s[OFS_W-1:0];
                  accc_d = accc_s[SIZE_W-1:0];
                end
                state_d = ST_RMW;
              end
            end
            CMD_START: begin
              row_d  = '0;
              col_d  = '0;
              ocol_d = '0;
              accc_d = '0;
              orow_d = '0;
              accr_d = '0;
              ev_d   = 1'b0;
            end
            CMD_CLEAR: begin
              fill_d     = in_i.fill_value;
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RMW: begin
        if (!emit) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_pixel_d    = transp_q ? rd_q : pix_q;
          out_position_d = pos;
          last_d         = pos;
          ev_d           = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == '1) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (cfg_we) calc_req_d = 1'b1;
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      calc_req_q  <= 1'b0;
      cnt_q       <= '0;
      clr_addr_q  <= '0;
      row_q       <= '0;
      col_q       <= '0;
      ev_q        <= 1'b0;
      out_valid_q <= 1'b0;
      scr_w_q     <= SIZE_W'(256);
      win_left_q  <= '0;
      win_top_q   <= '0;
      win_w_q     <= SIZE_W'(256);
      win_h_q     <= SIZE_W'(256);
      scl_w_q     <= SIZE_W'(128);
      scl_h_q     <= SIZE_W'(128);
      key_q       <= SIZE_W'(256);
    end else begin
      state_q     <= state_d;
      calc_req_q  <= calc_req_d;
      cnt_q       <= cnt_d;
      clr_addr_q  <= clr_addr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      ev_q        <= ev_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        case (cfg_i.index)
          REG_SCREEN_WIDTH:    scr_w_q    <= cfg_i.data;
          REG_WIN_LEFT:        win_left_q <= cfg_i.data[OFS_W-1:0];
          REG_WIN_TOP:         win_top_q  <= cfg_i.data[OFS_W-1:0];
          REG_WIN_WIDTH:       win_w_q    <= cfg_i.data;
          REG_WIN_HEIGHT:      win_h_q    <= cfg_i.data;
          REG_SCALED_WIDTH:    scl_w_q    <= cfg_i.data;
          REG_SCALED_HEIGHT:   scl_h_q    <= cfg_i.data;
          REG_TRANSPARENT_KEY: key_q      <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q          <= div_d;
    qc_q           <= qc_d;
    rc_q           <= rc_d;
    qr_q           <= qr_d;
    rr_q           <= rr_d;
    ocol_q         <= ocol_d;
    accc_q         <= accc_d;
    orow_q         <= orow_d;
    accr_q         <= accr_d;
    pix_q          <= pix_d;
    fill_q         <= fill_d;
    transp_q       <= transp_d;
    po_row_q       <= po_row_d;
    po_col_q       <= po_col_d;
    last_q         <= last_d;
    out_pixel_q    <= out_pixel_d;
    out_position_q <= out_position_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_addr];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_pixel    = out_pixel_q;
  assign out_o.out_position = out_position_q;

  a_store_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store written and read in one cycle");

  a_pixel_to_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_go |=> (state_q == ST_RMW))
    else $error("accepted pixel did not enter its second cycle");

  a_read_is_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> transp_q)
    else $error("store read for an opaque pixel");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_addr_q == '1) |=> (state_q == ST_IDLE))
    else $error("clear sweep did not end at the last entry");

  a_calc_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && cnt_q == CNT_LAST && !calc_req_q) |=> (state_q == ST_IDLE))
    else $error("divider bank did not finish");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=>
      (out_valid_q && $stable(out_pixel_q) && $stable(out_position_q)))
    else $error("output item changed while stalled");

endmodule

// ===== dv/tb_palette_frame_downscaler.sv =====
module tb_palette_frame_downscaler;
  import pfd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1050;

  typedef struct packed {
    bit [CMD_W-1:0] cmd;
    bit [PIX_W-1:0] pix;
    bit [PIX_W-1:0] fill;
    bit             drain;
  } cmd_item_t;

  typedef struct packed {
    bit [PIX_W-1:0] pixel;
    bit [POS_W-1:0] position;
  } scaled_pix_t;

  logic clk;
  logic rst_n;

  pfd_in_if  in_if ();
  pfd_out_if out_if ();
  pfd_cfg_if cfg_if ();

  palette_frame_downscaler u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  cmd_item_t   cmd_backlog[$];
  scaled_pix_t due_pixels[$];
  int unsigned mismatches = 0;

  bit [PIX_W-1:0]      screen_mirror [STORE_DEPTH];
  bit [SIZE_W-1:0]     regs_q [16];
  int unsigned         row_q = 0;
  int unsigned         col_q = 0;
  int unsigned         last_pos = 0;
  bit                  have_last = 1'b0;

  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;

  initial begin
    regs_q[REG_SCREEN_WIDTH]    = 9'd256;
    regs_q[REG_WIN_LEFT]        = 9'd0;
    regs_q[REG_WIN_TOP]         = 9'd0;
    regs_q[REG_WIN_WIDTH]       = 9'd256;
    regs_q[REG_WIN_HEIGHT]      = 9'd256;
    regs_q[REG_SCALED_WIDTH]    = 9'd128;
    regs_q[REG_SCALED_HEIGHT]   = 9'd128;
    regs_q[REG_TRANSPARENT_KEY] = 9'd256;
  end

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("tb_palette_frame_downscaler: done, errors");
    $finish;
  end

  function automatic int unsigned clamp_dim(bit [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void downscale_step(bit [CMD_W-1:0] cmd, bit [PIX_W-1:0] pix,
                                         bit [PIX_W-1:0] fill);
    int unsigned sw, ww, wh, ow, oh, addr, pos;
    bit [PIX_W-1:0] colour;
    scaled_pix_t    res;
    sw = clamp_dim(regs_q[REG_SCREEN_WIDTH]);
    ww = clamp_dim(regs_q[REG_WIN_WIDTH]);
    wh = clamp_dim(regs_q[REG_WIN_HEIGHT]);
    ow = clamp_dim(regs_q[REG_SCALED_WIDTH]);
    oh = clamp_dim(regs_q[REG_SCALED_HEIGHT]);
    if (cmd == CMD_START) begin
      row_q = 0;
      col_q = 0;
      have_last = 1'b0;
      last_pos = 0;
      return;
    end
    if (cmd == CMD_CLEAR) begin
      foreach (screen_mirror[i]) screen_mirror[i] = fill;
      return;
    end
    if (cmd != CMD_PIXEL || row_q >= wh) return;
    if (col_q >= ww) col_q = 0;
    addr = ((row_q + regs_q[REG_WIN_TOP][OFS_W-1:0]) * sw + col_q
            + regs_q[REG_WIN_LEFT][OFS_W-1:0]) % STORE_DEPTH;
    colour = pix;
    if ({1'b0, pix} == regs_q[REG_TRANSPARENT_KEY]) colour = screen_mirror[addr[ADDR_W-1:0]];
    else screen_mirror[addr[ADDR_W-1:0]] = pix;
    pos = (row_q * oh / wh) * ow + col_q * ow / ww;
    col_q++;
    if (col_q >= ww) begin
      col_q = 0;
      row_q++;
    end
    if (have_last && pos <= last_pos) return;
    have_last = 1'b1;
    last_pos = pos;
    res.pixel = colour;
    res.position = pos[POS_W-1:0];
    due_pixels.push_back(res);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.command <= CMD_PIXEL;
      in_if.pixel_value <= '0;
      in_if.fill_value <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        downscale_step(in_if.command, in_if.pixel_value, in_if.fill_value);
      if (!(in_if.valid && !in_if.ready)) begin
        if (in_gap != 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].drain && due_pixels.size() != 0)) begin
          in_if.valid <= 1'b1;
          in_if.command <= cmd_backlog[0].cmd;
          in_if.pixel_value <= cmd_backlog[0].pix;
          in_if.fill_value <= cmd_backlog[0].fill;
          void'(cmd_backlog.pop_front());
          in_gap = pick_gap(in_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    scaled_pix_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_pixels.size() == 0) begin
          $display("%0t: unexpected item pixel %02h position %0d", $time,
                   out_if.out_pixel, out_if.out_position);
          mismatches++;
        end else begin
          want = due_pixels.pop_front();
          if (want.pixel != out_if.out_pixel) begin
            $display("%0t: out_pixel expected %02h actual %02h", $time,
                     want.pixel, out_if.out_pixel);
            mismatches++;
          end
          if (want.position != out_if.out_position) begin
            $display("%0t: out_position expected %0d actual %0d", $time,
                     want.position, out_if.out_position);
            mismatches++;
          end
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) out_stall = pick_gap(out_calm);
      end
    end
  end

  task automatic push(bit [CMD_W-1:0] cmd, bit [PIX_W-1:0] pix,
                      bit [PIX_W-1:0] fill = 8'h00, bit drain = 1'b0);
    cmd_item_t it;
    it.cmd = cmd;
    it.pix = pix;
    it.fill = fill;
    it.drain = drain;
    cmd_backlog.push_back(it);
  endtask

  // hold until drained, past any clear sweep and the tail of a dropped pixel
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || in_if.valid || due_pixels.size() != 0);
    repeat (4) @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_e r, bit [SIZE_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data <= d;
    do @(posedge clk);
    while (!(cfg_if.valid && cfg_if.ready));
    regs_q[r] = d;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [SIZE_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 9'd0;
    if (r < 12) return 9'd256;
    if (r < 17) return SIZE_W'($urandom_range(257, 511));
    if (r < 30) return SIZE_W'($urandom_range(11, 255));
    return SIZE_W'($urandom_range(1, 10));
  endfunction

  function automatic bit [SIZE_W-1:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 9'd0;
    if (r < 30) return $urandom_range(0, 1) ? 9'h0FF : 9'h1FF;
    return SIZE_W'($urandom_range(0, 511));
  endfunction

  function automatic bit [SIZE_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return SIZE_W'($urandom_range(0, 255));
    if (r < 60) return 9'd256;
    if (r < 75) return SIZE_W'($urandom_range(257, 511));
    return SIZE_W'($urandom_range(0, 15));
  endfunction

  function automatic bit [PIX_W-1:0] pick_pix();
    if (regs_q[REG_TRANSPARENT_KEY] < 256 && $urandom_range(0, 3) == 0)
      return regs_q[REG_TRANSPARENT_KEY][PIX_W-1:0];
    return PIX_W'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned n_rand, phase, remaining, area, n, r, k;
    bit          first_frame;
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SCREEN_WIDTH;
    cfg_if.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: half-size output, compositing off
    push(CMD_CLEAR, 8'hFF, 8'h5A);
    push(CMD_START, 8'h00, 8'hFF);
    push(CMD_PIXEL, 8'h00);
    push(CMD_PIXEL, 8'hFF);
    push(CMD_PIXEL, 8'h80);
    push(CMD_RESERVED, 8'hFF, 8'hFF);
    push(CMD_PIXEL, 8'h01);
    wait_idle();

    write_reg(REG_SCREEN_WIDTH, 9'd16);
    write_reg(REG_WIN_LEFT, 9'd3);
    write_reg(REG_WIN_TOP, 9'd2);
    write_reg(REG_WIN_WIDTH, 9'd5);
    write_reg(REG_WIN_HEIGHT, 9'd3);
    write_reg(REG_SCALED_WIDTH, 9'd3);
    write_reg(REG_SCALED_HEIGHT, 9'd2);
    write_reg(REG_TRANSPARENT_KEY, 9'd7);
    push(CMD_START, 8'h00, 8'h00, 1'b1);
    push(CMD_PIXEL, 8'd7);
    push(CMD_PIXEL, 8'hFF);
    push(CMD_PIXEL, 8'd7);
    push(CMD_PIXEL, 8'h00);
    push(CMD_PIXEL, 8'h55);
    push(CMD_PIXEL, 8'hAA);
    push(CMD_PIXEL, 8'd7);
    push(CMD_PIXEL, 8'h01);
    push(CMD_PIXEL, 8'h80);
    push(CMD_PIXEL, 8'd7);
    push(CMD_PIXEL, 8'h7F);
    push(CMD_PIXEL, 8'hFE);
    push(CMD_PIXEL, 8'd7);
    push(CMD_PIXEL, 8'h33);
    push(CMD_PIXEL, 8'h44);
    push(CMD_PIXEL, 8'h99);
    push(CMD_PIXEL, 8'd7);
    push(CMD_START, 8'hFF, 8'h00);
    push(CMD_PIXEL, 8'd7);

    n_rand = 0;
    phase = 0;
    first_frame = 1'b1;
    while (n_rand < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0) begin
        write_reg(REG_SCREEN_WIDTH, 9'd256);
        write_reg(REG_WIN_LEFT, 9'd255);
        write_reg(REG_WIN_TOP, 9'd255);
        write_reg(REG_WIN_WIDTH, 9'd256);
        write_reg(REG_WIN_HEIGHT, 9'd256);
        write_reg(REG_SCALED_WIDTH, 9'd256);
        write_reg(REG_SCALED_HEIGHT, 9'd256);
        write_reg(REG_TRANSPARENT_KEY, 9'd0);
      end else if (phase == 1) begin
        write_reg(REG_SCREEN_WIDTH, 9'd0);
        write_reg(REG_WIN_LEFT, 9'd0);
        write_reg(REG_WIN_TOP, 9'd0);
        write_reg(REG_WIN_WIDTH, 9'd0);
        write_reg(REG_WIN_HEIGHT, 9'd0);
        write_reg(REG_SCALED_WIDTH, 9'd0);
        write_reg(REG_SCALED_HEIGHT, 9'd0);
        write_reg(REG_TRANSPARENT_KEY, 9'h1FF);
      end else begin
        write_reg(REG_SCREEN_WIDTH, pick_dim());
        write_reg(REG_WIN_LEFT, pick_offset());
        write_reg(REG_WIN_TOP, pick_offset());
        write_reg(REG_WIN_WIDTH, pick_dim());
        write_reg(REG_WIN_HEIGHT, pick_dim());
        write_reg(REG_SCALED_WIDTH, pick_dim());
        write_reg(REG_SCALED_HEIGHT, pick_dim());
        write_reg(REG_TRANSPARENT_KEY, pick_key());
      end

      if (phase == 4 || phase == 10) begin
        push(CMD_CLEAR, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
        n_rand++;
      end

      area = clamp_dim(regs_q[REG_WIN_WIDTH]) * clamp_dim(regs_q[REG_WIN_HEIGHT]);
      remaining = $urandom_range(50, 120);
      while (remaining > 0) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          push(CMD_START, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
               first_frame || $urandom_range(0, 9) == 0);
          first_frame = 1'b0;
          n = (area < remaining) ? area : remaining;
          if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
          for (k = 0; k < n; k++)
            push(CMD_PIXEL, pick_pix(), PIX_W'($urandom_range(0, 255)));
          remaining -= n;
          n_rand += n + 1;
          if (n == area && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3))
              push(CMD_PIXEL, pick_pix(), PIX_W'($urandom_range(0, 255)));
          end
        end else if (r < 88) begin
          n = $urandom_range(1, 5);
          for (k = 0; k < n; k++)
            push(CMD_PIXEL, pick_pix(), PIX_W'($urandom_range(0, 255)));
          remaining = (remaining > n) ? remaining - n : 0;
          n_rand += n;
        end else if (r < 94) begin
          push(CMD_RESERVED, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
          remaining--;
        end else begin
          push(CMD_START, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
          remaining--;
          n_rand++;
        end
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_palette_frame_downscaler: done, clean");
    end else begin
      $display("tb_palette_frame_downscaler: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pfd_pkg.sv
sv/pfd_if.sv
sv/palette_frame_downscaler.sv
dv/tb_palette_frame_downscaler.sv
